// ----- rtl/core/inb_pkg.sv -----
package inb_pkg;

  // Fixed field widths of the sample channel and the datapath.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 32;
  localparam int AVG_W    = 48;
  localparam int RATIO_W  = 16;
  localparam int PROD_W   = RATIO_W + AVG_W / 2;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [0:0] REG_ENABLE = 1'b0;
  localparam logic [0:0] REG_RATIO  = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd2560;

  typedef enum logic {
    OP_PASS,
    OP_BLANK
  } inb_op_t;

  typedef enum logic [1:0] {
    ST_SQUARE,
    ST_AVG,
    ST_MUL,
    ST_FIN
  } inb_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
  } inb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic                       was_blanked;
  } inb_out_t;

  typedef struct packed {
    inb_op_t op;
    inb_in_t sample;
  } inb_qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } inb_qstat_t;

endpackage

// ----- rtl/core/inb_ram.sv -----
module inb_ram
  #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/inb_front.sv -----
module inb_front
  import inb_pkg::*;
  (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  inb_in_t    in_data,
    input  logic       blanker_enable,
    input  inb_qstat_t q_stat,
    output logic       q_push,
    output inb_qent_t  q_push_ent
  );

  logic      hold_valid_r;
  logic      hold_valid_nxt;
  inb_qent_t hold_r;
  inb_qent_t hold_nxt;

  // The holding register is free once its item moves into the queue.
  always_comb begin
    q_push         = hold_valid_r && !q_stat.full;
    in_stall       = hold_valid_r && q_stat.full;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (!in_stall) begin
      hold_valid_nxt    = in_valid;
      hold_nxt.sample   = in_data;
      hold_nxt.op       = blanker_enable ? OP_BLANK : OP_PASS;
    end
  end

  assign q_push_ent = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

// ----- rtl/core/inb_queue.sv -----
module inb_queue
  import inb_pkg::*;
  (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  inb_qent_t  push_ent,
    input  logic       pop,
    output inb_qent_t  head,
    output inb_qstat_t stat
  );

  localparam int QDEPTH = 2;

  inb_qent_t                   ent_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]   wr_ptr_r;
  logic [$clog2(QDEPTH)-1:0]   wr_ptr_nxt;
  logic [$clog2(QDEPTH)-1:0]   rd_ptr_r;
  logic [$clog2(QDEPTH)-1:0]   rd_ptr_nxt;
  logic [$clog2(QDEPTH+1)-1:0] count_r;
  logic [$clog2(QDEPTH+1)-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (count_r == ($clog2(QDEPTH+1))'(QDEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ----- rtl/core/inb_back.sv -----
module inb_back
  import inb_pkg::*;
  #(
    parameter int RING_DEPTH  = 8,
    parameter int HANG_LEN    = 7,
    parameter int READ_OFFSET = 0
  )
  (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RATIO_W-1:0] trigger_ratio,
    input  inb_qent_t          head,
    input  inb_qstat_t         q_stat,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output inb_out_t           out_data
  );

  localparam int PW         = $clog2(RING_DEPTH);
  localparam int HW         = $clog2(HANG_LEN + 1);
  localparam int SQ_W       = 2 * SAMPLE_W - 1;
  localparam int X66_W      = AVG_W + 7;
  localparam int DEC_W      = X66_W - 16;
  localparam int MX_W       = MAG_W + 7;
  localparam int HALF_W     = AVG_W / 2;
  localparam int RD_RESET   = (RING_DEPTH - (READ_OFFSET % RING_DEPTH)) % RING_DEPTH;
  localparam bit ZERO_DELAY = (READ_OFFSET % RING_DEPTH) == 0;

  inb_state_t state_r;
  inb_state_t state_nxt;

  logic [PW-1:0]         wr_pos_r, wr_pos_nxt;
  logic [PW-1:0]         rd_pos_r, rd_pos_nxt;
  logic [RING_DEPTH-1:0] ring_vld_r, ring_vld_nxt;
  logic [AVG_W-1:0]      avg_r, avg_nxt;
  logic [HW-1:0]         hang_r, hang_nxt;
  logic                  out_valid_r, out_valid_nxt;
  inb_out_t              out_data_r, out_data_nxt;

  inb_in_t               smp_r, smp_nxt;
  logic [SQ_W-1:0]       isq_r, isq_nxt;
  logic [SQ_W-1:0]       qsq_r, qsq_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [PROD_W-1:0]     phi_r, phi_nxt;
  logic [PROD_W-1:0]     plo_r, plo_nxt;
  logic                  rd_vld_r, rd_vld_nxt;

  logic signed [2*SAMPLE_W-1:0] isq_full;
  logic signed [2*SAMPLE_W-1:0] qsq_full;
  logic [MAG_W-1:0]      mag_c;
  logic [X66_W-1:0]      avg_x66;
  logic [DEC_W-1:0]      dec;
  logic [MX_W-1:0]       mag_x66;
  logic [AVG_W:0]        avg_sum;
  logic [PROD_W-1:0]     thr;
  logic                  trig;
  logic [HW-1:0]         hang_eff;
  logic                  blank;
  logic                  out_free;
  logic                  ram_we;
  logic [2*SAMPLE_W-1:0] ram_rdata;
  inb_in_t               ring_smp;
  inb_in_t               delayed;

  inb_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (head.sample),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  assign ring_smp = ram_rdata;

  // Squares of the queue head, taken as the item leaves the queue.
  assign isq_full = head.sample.in_i * head.sample.in_i;
  assign qsq_full = head.sample.in_q * head.sample.in_q;

  // Average update: avg - floor(avg*66/2^16) + mag*66, all by shifts and adds.
  assign mag_c   = {1'b0, isq_r} + {1'b0, qsq_r};
  assign avg_x66 = ({7'd0, avg_r} << 6) + ({7'd0, avg_r} << 1);
  assign dec     = avg_x66[X66_W-1:16];
  assign mag_x66 = ({7'd0, mag_c} << 6) + ({7'd0, mag_c} << 1);
  assign avg_sum = {1'b0, avg_r} - {{(AVG_W + 1 - DEC_W){1'b0}}, dec}
                   + {{(AVG_W + 1 - MX_W){1'b0}}, mag_x66};

  // Threshold floor(ratio*avg/2^24) from the two registered partial products.
  assign thr      = phi_r + {{HALF_W{1'b0}}, plo_r[PROD_W-1:HALF_W]};
  assign trig     = (hang_r == '0) && ({{(PROD_W - MAG_W){1'b0}}, mag_r} > thr);
  assign hang_eff = trig ? HW'(HANG_LEN) : hang_r;
  assign blank    = (hang_eff != '0);

  assign delayed  = ZERO_DELAY ? smp_r : (rd_vld_r ? ring_smp : '0);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SQUARE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    ring_vld_nxt  = ring_vld_r;
    avg_nxt       = avg_r;
    hang_nxt      = hang_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    smp_nxt       = smp_r;
    isq_nxt       = isq_r;
    qsq_nxt       = qsq_r;
    mag_nxt       = mag_r;
    phi_nxt       = phi_r;
    plo_nxt       = plo_r;
    rd_vld_nxt    = rd_vld_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      ST_SQUARE: begin
        if (!q_stat.empty) begin
          if (head.op == OP_PASS) begin
            if (out_free) begin
              q_pop                    = 1'b1;
              out_valid_nxt            = 1'b1;
              out_data_nxt.out_i       = head.sample.in_i;
              out_data_nxt.out_q       = head.sample.in_q;
              out_data_nxt.was_blanked = 1'b0;
            end
          end else begin
            q_pop                  = 1'b1;
            ram_we                 = 1'b1;
            ring_vld_nxt[wr_pos_r] = 1'b1;
            smp_nxt                = head.sample;
            isq_nxt                = isq_full[SQ_W-1:0];
            qsq_nxt                = qsq_full[SQ_W-1:0];
            state_nxt              = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        mag_nxt   = mag_c;
        avg_nxt   = avg_sum[AVG_W-1:0];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        phi_nxt    = trigger_ratio * avg_r[AVG_W-1:HALF_W];
        plo_nxt    = trigger_ratio * avg_r[HALF_W-1:0];
        rd_vld_nxt = ring_vld_r[rd_pos_r];
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_i       = blank ? '0 : delayed.in_i;
          out_data_nxt.out_q       = blank ? '0 : delayed.in_q;
          out_data_nxt.was_blanked = blank;
          hang_nxt                 = blank ? hang_eff - 1'b1 : '0;
          wr_pos_nxt = (wr_pos_r == PW'(RING_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
          rd_pos_nxt = (rd_pos_r == PW'(RING_DEPTH - 1)) ? '0 : rd_pos_r + 1'b1;
          state_nxt  = ST_SQUARE;
        end
      end
      default: begin
        state_nxt = ST_SQUARE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= PW'(RD_RESET);
      ring_vld_r  <= '0;
      avg_r       <= '0;
      hang_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      ring_vld_r  <= ring_vld_nxt;
      avg_r       <= avg_nxt;
      hang_r      <= hang_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    smp_r      <= smp_nxt;
    isq_r      <= isq_nxt;
    qsq_r      <= qsq_nxt;
    mag_r      <= mag_nxt;
    phi_r      <= phi_nxt;
    plo_r      <= plo_nxt;
    rd_vld_r   <= rd_vld_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/impulse_noise_blanker_top.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  inb_in_t  (in_i, in_q)
// out_      output     out_valid/out_stall  inb_out_t (out_i, out_q, was_blanked)
// APB       input      psel/penable/pready  blanker_enable at 0x0, trigger_ratio at 0x4
//
// An item entering with the blanker enabled passes four steps in the back sequencer
// (square, average update, threshold multiply, decide), and the sequencer takes no new
// item until decide is done. With the blanker disabled an item leaves the queue straight
// into the output register. Items pass the front holding register, then the two-entry queue.
// Reset is synchronous and active low; the ring is cleared by per-entry valid bits,
// so no clearing pass is needed and items are taken right after reset.
// The input stalls only when the holding register and the queue are both full. While a
// result waits, an enabled item gets through its first three steps and holds at decide.
module impulse_noise_blanker_top
  import inb_pkg::*;
  #(
    parameter int RING_DEPTH  = 8,
    parameter int HANG_LEN    = 7,
    parameter int READ_OFFSET = 0
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  inb_in_t               in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output inb_out_t              out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
  );

  // Configuration registers. Registers sit on 32-bit word addresses, so bit 2 of
  // the address picks one of the two.
  logic               enable_r;
  logic               enable_nxt;
  logic [RATIO_W-1:0] ratio_r;
  logic [RATIO_W-1:0] ratio_nxt;
  logic [0:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    enable_nxt = enable_r;
    ratio_nxt  = ratio_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE: enable_nxt = pwdata[0];
        REG_RATIO:  ratio_nxt  = pwdata[RATIO_W-1:0];
        default: begin
          enable_nxt = enable_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE: prdata = {{(CFG_DATA_W - 1){1'b0}}, enable_r};
      REG_RATIO:  prdata = {{(CFG_DATA_W - RATIO_W){1'b0}}, ratio_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      ratio_r  <= RATIO_RESET;
    end else begin
      enable_r <= enable_nxt;
      ratio_r  <= ratio_nxt;
    end
  end

  // The front tags each item as pass-through or blanking work, the queue decouples
  // it from the back end, and the back end runs the average, trigger and ring.
  logic       q_push;
  logic       q_pop;
  inb_qent_t  q_push_ent;
  inb_qent_t  q_head;
  inb_qstat_t q_stat;

  inb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .blanker_enable (enable_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_push_ent     (q_push_ent)
  );

  inb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  inb_back #(
    .RING_DEPTH  (RING_DEPTH),
    .HANG_LEN    (HANG_LEN),
    .READ_OFFSET (READ_OFFSET)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .trigger_ratio (ratio_r),
    .head          (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  // The front never pushes into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The back end only takes items that are present.
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A blanked result carries a zero sample.
  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_blanked) |-> (out_data.out_i == '0 && out_data.out_q == '0))
    else $error("blanked result with nonzero sample");

endmodule
